>>> src/mi3_pkg.sv
// Shared widths, payload words and divider stage records for the 3x3 inverse.
package mi3_pkg;

    localparam int M_W     = 16;   // Q8.8 matrix entry
    localparam int P_W     = 32;   // product of two entries
    localparam int C_W     = 33;   // cofactor, Q17.16
    localparam int DP_W    = 48;   // entry times cofactor
    localparam int DET_W   = 50;   // determinant, Q26.24, signed
    localparam int DMAG_W  = 50;   // determinant magnitude
    localparam int NUM_W   = 57;   // cofactor magnitude shifted up by FRAC_SH
    localparam int Q_W     = 32;   // quotient bits
    localparam int CMP_W   = 83;   // compare width for shifted divisor
    localparam int FRAC_SH = 24;
    localparam int N_LANE  = 9;

    typedef struct packed {
        logic signed [M_W-1:0] m_r0_c0;
        logic signed [M_W-1:0] m_r0_c1;
        logic signed [M_W-1:0] m_r0_c2;
        logic signed [M_W-1:0] m_r1_c0;
        logic signed [M_W-1:0] m_r1_c1;
        logic signed [M_W-1:0] m_r1_c2;
        logic signed [M_W-1:0] m_r2_c0;
        logic signed [M_W-1:0] m_r2_c1;
        logic signed [M_W-1:0] m_r2_c2;
    } t_in_word;

    typedef struct packed {
        logic signed [Q_W-1:0] inv_r0_c0;
        logic signed [Q_W-1:0] inv_r0_c1;
        logic signed [Q_W-1:0] inv_r0_c2;
        logic signed [Q_W-1:0] inv_r1_c0;
        logic signed [Q_W-1:0] inv_r1_c1;
        logic signed [Q_W-1:0] inv_r1_c2;
        logic signed [Q_W-1:0] inv_r2_c0;
        logic signed [Q_W-1:0] inv_r2_c1;
        logic signed [Q_W-1:0] inv_r2_c2;
        logic                  singular;
    } t_out_word;

    typedef struct packed {
        logic [NUM_W-1:0] rem;
        logic [Q_W-1:0]   q;
        logic             neg;
        logic             ovf;
    } t_lane;

    typedef struct packed {
        logic                         singular;
        logic [DMAG_W-1:0]            dmag;
        t_lane [N_LANE-1:0]           lane;
    } t_div;

endpackage

>>> src/mi3_cofactor.sv
// Four-stage cofactor and determinant pipeline.
module mi3_cofactor (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_en,
    input  logic                                i_valid,
    input  mi3_pkg::t_in_word                   i_data,
    output logic                                o_valid,
    output logic signed [mi3_pkg::C_W-1:0]      o_cof [3][3],
    output logic signed [mi3_pkg::DET_W-1:0]    o_det
);
    import mi3_pkg::*;

    logic signed [M_W-1:0]   w_m [3][3];
    logic signed [P_W-1:0]   r_pa [3][3];
    logic signed [P_W-1:0]   r_pb [3][3];
    logic signed [M_W-1:0]   r_m0_s1 [3];
    logic signed [M_W-1:0]   r_m0_s2 [3];
    logic signed [C_W-1:0]   r_cof_s2 [3][3];
    logic signed [C_W-1:0]   r_cof_s3 [3][3];
    logic signed [DP_W-1:0]  r_dp [3];
    logic signed [DET_W-1:0] r_det;
    logic [3:0]              r_v;

    assign w_m[0][0] = i_data.m_r0_c0;
    assign w_m[0][1] = i_data.m_r0_c1;
    assign w_m[0][2] = i_data.m_r0_c2;
    assign w_m[1][0] = i_data.m_r1_c0;
    assign w_m[1][1] = i_data.m_r1_c1;
    assign w_m[1][2] = i_data.m_r1_c2;
    assign w_m[2][0] = i_data.m_r2_c0;
    assign w_m[2][1] = i_data.m_r2_c1;
    assign w_m[2][2] = i_data.m_r2_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[2:0], i_valid};
        end
    end

    for (genvar gi = 0; gi < 3; gi++) begin : g_row
        localparam int I1 = (gi + 1) % 3;
        localparam int I2 = (gi + 2) % 3;
        for (genvar gj = 0; gj < 3; gj++) begin : g_col
            localparam int J1 = (gj + 1) % 3;
            localparam int J2 = (gj + 2) % 3;
            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_pa[gi][gj]     <= w_m[I1][J1] * w_m[I2][J2];
                    r_pb[gi][gj]     <= w_m[I1][J2] * w_m[I2][J1];
                    r_cof_s2[gi][gj] <= C_W'(r_pa[gi][gj]) - C_W'(r_pb[gi][gj]);
                    r_cof_s3[gi][gj] <= r_cof_s2[gi][gj];
                    o_cof[gi][gj]    <= r_cof_s3[gi][gj];
                end
            end
        end
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_m0_s1[gi] <= w_m[0][gi];
                r_m0_s2[gi] <= r_m0_s1[gi];
                r_dp[gi]    <= r_m0_s2[gi] * r_cof_s2[0][gi];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_det <= DET_W'(r_dp[0]) + DET_W'(r_dp[1]) + DET_W'(r_dp[2]);
        end
    end

    assign o_det   = r_det;
    assign o_valid = r_v[3];
endmodule

>>> src/mi3_div_step.sv
// One restoring-division bit for all nine lanes.
module mi3_div_step #(
    parameter int K = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  logic          i_valid,
    input  mi3_pkg::t_div i_div,
    output logic          o_valid,
    output mi3_pkg::t_div o_div
);
    import mi3_pkg::*;

    logic [CMP_W-1:0] w_dsh;
    t_div             n_div;

    assign w_dsh = CMP_W'(i_div.dmag) << K;

    always_comb begin
        n_div = i_div;
        for (int l = 0; l < N_LANE; l++) begin
            if (CMP_W'(i_div.lane[l].rem) >= w_dsh) begin
                n_div.lane[l].rem  = i_div.lane[l].rem - w_dsh[NUM_W-1:0];
                n_div.lane[l].q[K] = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_div <= n_div;
        end
    end
endmodule

>>> src/matrix_inverse_3x3.sv
// Throughput: one matrix per cycle; every stage advances together while the
//   output register is empty or being taken, so a stall holds the whole pipe.
// Stages: 4 cofactor/determinant, 1 sign and overflow prep, 32 quotient bits
//   (one restoring step per stage, nine lanes), 1 saturation/output register.
// Reset: synchronous active-low i_rst_n clears all stage valid bits.
module matrix_inverse_3x3 (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  mi3_pkg::t_in_word  i_data,
    output logic               o_valid,
    input  logic               i_ready,
    output mi3_pkg::t_out_word o_data
);
    import mi3_pkg::*;

    // advance every stage when the output register can move
    logic w_en;
    assign w_en    = !o_valid || i_ready;
    assign o_ready = w_en;

    logic                    w_cof_valid;
    logic signed [C_W-1:0]   w_cof [3][3];
    logic signed [DET_W-1:0] w_det;

    mi3_cofactor u_cof (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_valid (w_cof_valid),
        .o_cof   (w_cof),
        .o_det   (w_det)
    );

    // prep: magnitudes, result sign, transpose into lanes, overflow test
    t_div              n_pre;
    t_div              r_pre;
    logic              r_pre_valid;
    logic [C_W-1:0]    w_cabs [N_LANE];
    logic [DMAG_W-1:0] w_dmag;
    logic [CMP_W-1:0]  w_dtop;

    assign w_dmag = w_det[DET_W-1] ? DMAG_W'(-w_det) : DMAG_W'(w_det);
    assign w_dtop = CMP_W'(w_dmag) << Q_W;

    always_comb begin
        n_pre          = '0;
        n_pre.singular = (w_det == '0);
        n_pre.dmag     = w_dmag;
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                // inverse (i,j) takes cofactor (j,i)
                w_cabs[i*3+j] = w_cof[j][i][C_W-1] ? C_W'(-w_cof[j][i]) : C_W'(w_cof[j][i]);
                n_pre.lane[i*3+j].rem = {w_cabs[i*3+j], {FRAC_SH{1'b0}}};
                n_pre.lane[i*3+j].neg = w_cof[j][i][C_W-1] ^ w_det[DET_W-1];
                n_pre.lane[i*3+j].ovf =
                    (CMP_W'(n_pre.lane[i*3+j].rem) >= w_dtop);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pre_valid <= 1'b0;
        end else if (w_en) begin
            r_pre_valid <= w_cof_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pre <= n_pre;
        end
    end

    // quotient bits, most significant first
    logic w_sv [Q_W+1];
    t_div w_sd [Q_W+1];

    assign w_sv[0] = r_pre_valid;
    assign w_sd[0] = r_pre;

    for (genvar gs = 0; gs < Q_W; gs++) begin : g_step
        mi3_div_step #(.K(Q_W - 1 - gs)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_sv[gs]),
            .i_div   (w_sd[gs]),
            .o_valid (w_sv[gs+1]),
            .o_div   (w_sd[gs+1])
        );
    end

    // saturate, apply sign, zero on singular
    logic [Q_W-1:0] w_res [N_LANE];
    t_out_word      n_out;

    always_comb begin
        for (int l = 0; l < N_LANE; l++) begin
            if (w_sd[Q_W].singular) begin
                w_res[l] = '0;
            end else if (w_sd[Q_W].lane[l].ovf || w_sd[Q_W].lane[l].q[Q_W-1]) begin
                w_res[l] = w_sd[Q_W].lane[l].neg ? {1'b1, {(Q_W-1){1'b0}}}
                                                 : {1'b0, {(Q_W-1){1'b1}}};
            end else begin
                w_res[l] = w_sd[Q_W].lane[l].neg ? -w_sd[Q_W].lane[l].q
                                                 : w_sd[Q_W].lane[l].q;
            end
        end
        n_out.inv_r0_c0 = w_res[0];
        n_out.inv_r0_c1 = w_res[1];
        n_out.inv_r0_c2 = w_res[2];
        n_out.inv_r1_c0 = w_res[3];
        n_out.inv_r1_c1 = w_res[4];
        n_out.inv_r1_c2 = w_res[5];
        n_out.inv_r2_c0 = w_res[6];
        n_out.inv_r2_c1 = w_res[7];
        n_out.inv_r2_c2 = w_res[8];
        n_out.singular  = w_sd[Q_W].singular;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= w_sv[Q_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_data <= n_out;
        end
    end

    // singular results carry zero in the three diagonal entries and in inv_r0_c1, inv_r1_c2 and inv_r2_c0
    a_singular_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_data.singular |->
            o_data.inv_r0_c0 == '0 && o_data.inv_r1_c1 == '0 && o_data.inv_r2_c2 == '0
            && o_data.inv_r0_c1 == '0 && o_data.inv_r1_c2 == '0 && o_data.inv_r2_c0 == '0)
        else $error("singular result with nonzero inverse");

    // a cofactor word moves into prep whenever the pipe advances
    a_prep_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cof_valid && w_en |=> r_pre_valid)
        else $error("cofactor word lost at prep");

    // a stall freezes the prep stage
    a_prep_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_en |=> $stable(r_pre_valid) && $stable(r_pre))
        else $error("prep stage moved during stall");
endmodule

>>> verif/matrix_inverse_3x3_test.sv
// Testbench for the pipelined 3x3 adjugate inverse: directed table, random matrices, checks.
`timescale 1ns / 100ps

module matrix_inverse_3x3_test;
    import mi3_pkg::*;

    localparam int N_RANDOM   = 950;
    localparam int LATENCY    = 38;
    localparam int CYCLE_CAP  = 400000;
    localparam int HOLD_LONG  = 200;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_ready;
    t_in_word   i_data;
    logic       o_valid;
    logic       i_ready;
    t_out_word  o_data;

    matrix_inverse_3x3 dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // directed row: matrix, and optionally a typed-in expected word
    typedef struct {
        t_in_word  mat;
        bit        fixed;
        t_out_word want;
    } t_row;

    t_out_word inverse_q[$];
    t_row      rows[$];
    int        errors;
    int        cycles;
    int        sent;
    int        got;
    int        singular_seen;
    int        sat_seen;
    bit        stim_done;
    bit        hold_off;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // saturate a quotient to 32 bits
    function automatic logic [31:0] clamp32(longint q);
        if (q > 64'sd2147483647) return 32'h7FFFFFFF;
        if (q < -64'sd2147483648) return 32'h80000000;
        return q[31:0];
    endfunction

    // compute the inverse word by cofactors over the exact determinant
    function automatic t_out_word invert(t_in_word w);
        longint    m[3][3];
        longint    cf[3][3];
        longint    det;
        logic [31:0] r[9];
        t_out_word o;
        m[0][0] = w.m_r0_c0; m[0][1] = w.m_r0_c1; m[0][2] = w.m_r0_c2;
        m[1][0] = w.m_r1_c0; m[1][1] = w.m_r1_c1; m[1][2] = w.m_r1_c2;
        m[2][0] = w.m_r2_c0; m[2][1] = w.m_r2_c1; m[2][2] = w.m_r2_c2;
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                cf[i][j] = m[(i+1)%3][(j+1)%3] * m[(i+2)%3][(j+2)%3]
                         - m[(i+1)%3][(j+2)%3] * m[(i+2)%3][(j+1)%3];
        det = m[0][0]*cf[0][0] + m[0][1]*cf[0][1] + m[0][2]*cf[0][2];
        o = '0;
        if (det == 0) begin
            o.singular = 1'b1;
            return o;
        end
        // num fits in 57 bits, so 64-bit signed division is exact
        for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++)
                r[i*3+j] = clamp32((cf[j][i] <<< 24) / det);
        o.inv_r0_c0 = r[0]; o.inv_r0_c1 = r[1]; o.inv_r0_c2 = r[2];
        o.inv_r1_c0 = r[3]; o.inv_r1_c1 = r[4]; o.inv_r1_c2 = r[5];
        o.inv_r2_c0 = r[6]; o.inv_r2_c1 = r[7]; o.inv_r2_c2 = r[8];
        o.singular  = 1'b0;
        return o;
    endfunction

    function automatic t_in_word diag(logic [15:0] a, logic [15:0] b, logic [15:0] c);
        t_in_word w;
        w = '0;
        w.m_r0_c0 = a; w.m_r1_c1 = b; w.m_r2_c2 = c;
        return w;
    endfunction

    function automatic t_in_word rand_word();
        t_in_word w;
        int       mode;
        logic [15:0] e[9];
        mode = $urandom_range(0, 9);
        for (int k = 0; k < 9; k++) begin
            case (mode)
                0, 1, 2, 3: e[k] = 16'($urandom);                    // full range
                4, 5:       e[k] = 16'($signed($urandom_range(0, 1023)) - 512);
                6:          e[k] = $urandom_range(0, 3) == 0 ? 16'h8000 :
                                   ($urandom_range(0, 1) ? 16'h7FFF : 16'($urandom));
                7:          e[k] = 16'($signed($urandom_range(0, 8)) - 4);  // often singular
                default:    e[k] = ($urandom_range(0, 2) == 0) ? 16'h0000 : 16'($urandom);
            endcase
        end
        // sometimes copy a row to force a zero determinant
        if (mode == 9 && $urandom_range(0, 1)) begin
            e[6] = e[0]; e[7] = e[1]; e[8] = e[2];
        end
        w = {e[0], e[1], e[2], e[3], e[4], e[5], e[6], e[7], e[8]};
        return w;
    endfunction

    task automatic add_row(t_in_word w, bit fx, t_out_word wt);
        t_row r;
        r.mat = w; r.fixed = fx; r.want = wt;
        rows.push_back(r);
    endtask

    task automatic send(t_in_word w, bit fx, t_out_word wt);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 9) == 0 ?
              $urandom_range(10, 60) : $urandom_range(1, 3)) : 0;
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        // hold the word until it is taken
        do @(posedge i_clk); while (!o_ready);
        inverse_q.push_back(fx ? wt : invert(w));
        sent++;
    endtask

    // sender: directed table, then random words
    initial begin
        t_out_word z, unit, sat;
        i_rst_n = 1'b0; i_valid = 1'b0; i_data = '0;
        errors = 0; sent = 0; stim_done = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        z = '0; z.singular = 1'b1;
        unit = '0;
        unit.inv_r0_c0 = 32'h00010000; unit.inv_r1_c1 = 32'h00010000;
        unit.inv_r2_c2 = 32'h00010000;
        sat = '0;
        sat.inv_r0_c0 = 32'h01000000; sat.inv_r1_c1 = 32'h01000000;
        sat.inv_r2_c2 = 32'h01000000;
        add_row('0, 1'b1, z);                                   // all zero: singular
        add_row(diag(16'h0100, 16'h0100, 16'h0100), 1'b1, unit);// identity
        add_row(diag(16'h0001, 16'h0001, 16'h0001), 1'b1, sat); // tiny: inverse of 256
        add_row({9{16'h7FFF}}, 1'b1, z);                        // equal rows: singular
        add_row({9{16'h8000}}, 1'b1, z);
        add_row(diag(16'h8000, 16'h8000, 16'h8000), 1'b0, z);
        add_row(diag(16'h7FFF, 16'h7FFF, 16'h7FFF), 1'b0, z);
        add_row(diag(16'h0001, 16'hFFFF, 16'h0001), 1'b0, z);   // negative determinant
        add_row(diag(16'h8000, 16'h0001, 16'h7FFF), 1'b0, z);
        add_row({16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h7FFF, 16'h8000,
                 16'h8000, 16'h0000, 16'h7FFF}, 1'b0, z);
        add_row({16'h0000, 16'h0100, 16'h0000, 16'h0100, 16'h0000, 16'h0000,
                 16'h0000, 16'h0000, 16'h0100}, 1'b0, z);       // permutation
        add_row({16'h0200, 16'h0100, 16'h0000, 16'h0100, 16'h0300, 16'h0100,
                 16'h0000, 16'h0100, 16'h0400}, 1'b0, z);
        add_row({16'hFFFF, 16'h5555, 16'hAAAA, 16'h1234, 16'h8001, 16'h7FFE,
                 16'h0F0F, 16'hF0F0, 16'hC3C3}, 1'b0, z);
        foreach (rows[k]) send(rows[k].mat, rows[k].fixed, rows[k].want);

        for (int n = 0; n < N_RANDOM; n++) send(rand_word(), 1'b0, z);
        i_valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stalls, one long hold-off while the pipe fills
    initial begin
        int stall;
        i_ready  = 1'b1;
        hold_off = 1'b0;
        @(posedge i_rst_n);
        wait (sent >= 100);
        @(posedge i_clk);
        i_ready <= 1'b0;
        hold_off = 1'b1;
        repeat (HOLD_LONG) @(posedge i_clk);
        hold_off = 1'b0;
        forever begin
            if ($urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                    : $urandom_range(1, 3);
                i_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
        end
    end

    task automatic cmp(string fld, logic [31:0] want, logic [31:0] act);
        if (want !== act) begin
            $display("%0t ERROR %s expected %h actual %h", $time, fld, want, act);
            errors++;
        end
    endtask

    // check every taken word against the oldest expected inverse
    always @(posedge i_clk) begin
        t_out_word w;
        if (i_rst_n && o_valid && i_ready) begin
            got++;
            if (inverse_q.size() == 0) begin
                $display("%0t ERROR unexpected word %h", $time, o_data);
                errors++;
            end else begin
                w = inverse_q.pop_front();
                if (w.singular) singular_seen++;
                if (w.inv_r0_c0 == 32'h7FFFFFFF || w.inv_r0_c0 == 32'h80000000) sat_seen++;
                cmp("inv_r0_c0", w.inv_r0_c0, o_data.inv_r0_c0);
                cmp("inv_r0_c1", w.inv_r0_c1, o_data.inv_r0_c1);
                cmp("inv_r0_c2", w.inv_r0_c2, o_data.inv_r0_c2);
                cmp("inv_r1_c0", w.inv_r1_c0, o_data.inv_r1_c0);
                cmp("inv_r1_c1", w.inv_r1_c1, o_data.inv_r1_c1);
                cmp("inv_r1_c2", w.inv_r1_c2, o_data.inv_r1_c2);
                cmp("inv_r2_c0", w.inv_r2_c0, o_data.inv_r2_c0);
                cmp("inv_r2_c1", w.inv_r2_c1, o_data.inv_r2_c1);
                cmp("inv_r2_c2", w.inv_r2_c2, o_data.inv_r2_c2);
                cmp("singular", 32'(w.singular), 32'(o_data.singular));
            end
        end
    end

    // end of run and watchdog
    initial begin
        cycles = 0; got = 0; singular_seen = 0; sat_seen = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles > CYCLE_CAP) begin
                $display("Timeout after %0d cycles", cycles);
                $display("Some tests failed");
                $finish;
            end
            if (stim_done && inverse_q.size() == 0) begin
                repeat (LATENCY + 10) @(posedge i_clk);
                $display("Ran %0d matrices, %0d results, %0d singular, %0d saturated",
                         sent, got, singular_seen, sat_seen);
                $display("Random stalls on both sides plus one long output hold-off");
                if (errors == 0 && inverse_q.size() == 0)
                    $display("All tests passed");
                else
                    $display("Some tests failed");
                $finish;
            end
        end
    end

endmodule

>>> sim.f
src/mi3_pkg.sv
src/mi3_cofactor.sv
src/mi3_div_step.sv
src/matrix_inverse_3x3.sv
verif/matrix_inverse_3x3_test.sv
